FILE: src/button_click_press_detector_macros.svh
// Assertion macros shared by the button detector RTL.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef BUTTON_CLICK_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_PRESS_DETECTOR_MACROS_SVH

// plain property check
`define BCPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BCPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bcpd_pkg.sv
// Package for the button click / press detector: widths, codes, types.
// No dependencies; used by the result interface, the core and the top level.
`timescale 1ns / 1ps

package bcpd_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int EV_W      = 3;
  localparam int HOLD_W    = 32;
  localparam int WIDE_W    = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_DOUBLE    = 2'd1,
    CFG_LONG      = 2'd2,
    CFG_VERY_LONG = 2'd3
  } cfg_idx_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE      = 3'd0,
    EV_PRESSED   = 3'd1,
    EV_RELEASED  = 3'd2,
    EV_CLICK     = 3'd3,
    EV_DOUBLE    = 3'd4,
    EV_LONG      = 3'd5,
    EV_VERY_LONG = 3'd6
  } ev_e;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_click_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] very_long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic raw_level;
    logic take_event;
  } tick_t;

  typedef struct packed {
    logic              is_pressed;
    logic [EV_W-1:0]   event_code;
    logic [HOLD_W-1:0] hold_time;
  } res_t;

endpackage

FILE: src/bcpd_if.sv
// Valid/ready channel interfaces: tick items in, result items out.
// Depends on bcpd_pkg for the field widths.
`timescale 1ns / 1ps

interface bcpd_in_if;
  logic valid;
  logic ready;
  logic raw_level;
  logic take_event;

  modport source (output valid, output raw_level, output take_event, input ready);
  modport sink   (input valid, input raw_level, input take_event, output ready);
endinterface

interface bcpd_out_if;
  import bcpd_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_pressed;
  logic [EV_W-1:0]   event_code;
  logic [HOLD_W-1:0] hold_time;

  modport source (output valid, output is_pressed, output event_code, output hold_time,
                  input ready);
  modport sink   (input valid, input is_pressed, input event_code, input hold_time,
                  output ready);
endinterface

FILE: src/bcpd_core.sv
// Detector state and one-tick update: debounce, click window, long press, event latch.
// Depends on bcpd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "button_click_press_detector_macros.svh"

module bcpd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  bcpd_pkg::tick_t tick_i,
  input  bcpd_pkg::cfg_t  cfg_i,
  output bcpd_pkg::res_t  res_o
);
  import bcpd_pkg::*;

  time_t now_q, now_d;
  time_t last_chg_q, last_chg_d;
  time_t press_q, press_d;
  time_t rel_q, rel_d;
  logic  prev_q, stable_q, stable_d, held_q, held_d;
  logic  await_q, await_d, taken_q, taken_d;
  ev_e   ev_q, ev_d;

  time_t el_chg, el_press, el_rel;
  time_t deb_w, dbl_w, long_w, vlong_w;
  logic  accept, press, release_ev;
  logic [WIDE_W-1:0] el_wide;
  ev_e   code;

  assign deb_w   = TIME_BITS'(cfg_i.debounce_ms);
  assign dbl_w   = TIME_BITS'(cfg_i.double_click_ms);
  assign long_w  = TIME_BITS'(cfg_i.long_press_ms);
  assign vlong_w = TIME_BITS'(cfg_i.very_long_press_ms);

  // edge times first, the elapsed counts below see the updated marks
  assign last_chg_d = (tick_i.raw_level != prev_q) ? now_q : last_chg_q;
  assign el_chg     = now_q - last_chg_d;
  assign accept     = (el_chg > deb_w) && (tick_i.raw_level != stable_q);
  assign press      = accept && !tick_i.raw_level;
  assign release_ev = accept && tick_i.raw_level;
  assign press_d    = press ? now_q : press_q;
  assign rel_d      = release_ev ? now_q : rel_q;
  assign el_press   = now_q - press_d;
  assign el_rel     = now_q - rel_d;
  assign stable_d   = accept ? tick_i.raw_level : stable_q;
  assign held_d     = press ? 1'b1 : (release_ev ? 1'b0 : held_q);
  assign now_d      = now_q + TIME_BITS'(1);
  assign el_wide    = WIDE_W'(el_press);

  always_comb begin
    ev_d    = ev_q;
    taken_d = taken_q;
    await_d = await_q;
    code    = EV_NONE;

    if (press) begin
      taken_d = 1'b0;
      if (await_q && (el_rel < dbl_w)) begin
        ev_d    = EV_DOUBLE;
        await_d = 1'b0;
      end else begin
        ev_d = EV_PRESSED;
      end
    end else if (release_ev) begin
      taken_d = 1'b0;
      if (el_press >= vlong_w) begin
        ev_d    = EV_VERY_LONG;
        await_d = 1'b0;
      end else if (el_press >= long_w) begin
        ev_d    = EV_LONG;
        await_d = 1'b0;
      end else begin
        ev_d    = EV_RELEASED;
        await_d = 1'b1;
      end
    end

    // double-click window ran out
    if (await_d && (el_rel >= dbl_w)) begin
      await_d = 1'b0;
      ev_d    = EV_CLICK;
      taken_d = 1'b0;
    end

    // upgrade a pending press while still held
    if (held_d && !taken_d && (ev_d == EV_PRESSED)) begin
      if (el_press >= vlong_w) begin
        ev_d    = EV_VERY_LONG;
        await_d = 1'b0;
      end else if (el_press >= long_w) begin
        ev_d = EV_LONG;
      end
    end

    if (tick_i.take_event && !taken_d) begin
      taken_d = 1'b1;
      code    = ev_d;
    end
  end

  always_comb begin
    res_o.is_pressed = held_d;
    res_o.event_code = code;
    if (!held_d) begin
      res_o.hold_time = '0;
    end else if (el_wide > WIDE_W'(HOLD_MAX)) begin
      res_o.hold_time = HOLD_MAX;
    end else begin
      res_o.hold_time = HOLD_W'(el_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      last_chg_q <= '0;
      press_q    <= '0;
      rel_q      <= '0;
      prev_q     <= 1'b1;
      stable_q   <= 1'b1;
      held_q     <= 1'b0;
      await_q    <= 1'b0;
      ev_q       <= EV_NONE;
      taken_q    <= 1'b1;
    end else if (step_i) begin
      now_q      <= now_d;
      last_chg_q <= last_chg_d;
      press_q    <= press_d;
      rel_q      <= rel_d;
      prev_q     <= tick_i.raw_level;
      stable_q   <= stable_d;
      held_q     <= held_d;
      await_q    <= await_d;
      ev_q       <= ev_d;
      taken_q    <= taken_d;
    end
  end

  `BCPD_ASSERT(held_tracks_level, held_q != stable_q, "held out of step with debounced level")
  `BCPD_ASSERT_IMP(no_window_while_held, await_q, !held_q, "click window open while held")
  `BCPD_ASSERT_NXT(idle_keeps_time, !step_i, $stable(now_q), "tick counter moved without item")

endmodule

FILE: src/button_click_press_detector.sv
// A tick is held in the input register, its result in the result register.
// Throughput: one item per cycle while out_o is ready; one registered state pass.
// Input register and result register decouple the two channels.
// Reset: asynchronous, active low; registers go to 50/300/1000/3000 ms,
// button released, no event pending, tick counter zero.
// Top level of the button detector; depends on bcpd_pkg, bcpd_if and bcpd_core.
`timescale 1ns / 1ps
`include "button_click_press_detector_macros.svh"

module button_click_press_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bcpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bcpd_pkg::CFG_W-1:0]       cfg_data_i,
  bcpd_in_if.sink                          in_i,
  bcpd_out_if.source                       out_o
);
  import bcpd_pkg::*;

  cfg_t  cfg_q;
  logic  in_vld_q, out_vld_q, adv;
  tick_t tick_q;
  res_t  res_q, core_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= CFG_W'(50);
      cfg_q.double_click_ms    <= CFG_W'(300);
      cfg_q.long_press_ms      <= CFG_W'(1000);
      cfg_q.very_long_press_ms <= CFG_W'(3000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:  cfg_q.debounce_ms        <= cfg_data_i;
        CFG_DOUBLE:    cfg_q.double_click_ms    <= cfg_data_i;
        CFG_LONG:      cfg_q.long_press_ms      <= cfg_data_i;
        CFG_VERY_LONG: cfg_q.very_long_press_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step when a tick waits and the result slot is free or being drained
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      tick_q.raw_level  <= in_i.raw_level;
      tick_q.take_event <= in_i.take_event;
    end
    if (adv) begin
      res_q <= core_res;
    end
  end

  bcpd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .tick_i (tick_q),
    .cfg_i  (cfg_q),
    .res_o  (core_res)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.is_pressed = res_q.is_pressed;
  assign out_o.event_code = res_q.event_code;
  assign out_o.hold_time  = res_q.hold_time;

  `BCPD_ASSERT_NXT(tick_kept, in_vld_q && !adv, in_vld_q, "pending tick dropped")
  `BCPD_ASSERT_IMP(no_overwrite, out_vld_q && !out_o.ready, !adv, "result overwritten")
  `BCPD_ASSERT_IMP(hold_zero_released, out_vld_q && !res_q.is_pressed, res_q.hold_time == '0,
                   "hold time nonzero while released")

endmodule
